/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
	`ASSERT_PROP(lbl, (ante) |-> (cons))
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

/* rtl/core/ftc_pkg.sv */
package ftc_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;

	localparam logic [7:0] MIN_PAYLOAD_RESET = 8'd7;

	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic [16:0] ETHER_BYTES = 17'd14;
	localparam logic [16:0] TAG_BYTES   = 17'd4;
	localparam logic [5:0]  UDP_BYTES   = 6'd8;

	localparam logic [2:0] STATUS_DROPPED    = 3'd0;
	localparam logic [2:0] STATUS_COUNTED    = 3'd1;
	localparam logic [2:0] STATUS_INSERTED   = 3'd2;
	localparam logic [2:0] STATUS_FULL       = 3'd3;
	localparam logic [2:0] STATUS_READ_VALID = 3'd4;
	localparam logic [2:0] STATUS_READ_EMPTY = 3'd5;

	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DROP  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  entry_index;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [16:0] frame_bytes;
	} cmd_t;

	typedef struct packed {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [31:0] packets;
		logic [31:0] bytes;
	} row_t;

endpackage

/* rtl/core/flow_tuple_packet_byte_counter.sv */
// Five-tuple flow counter. Items are classified on entry and queued (two deep);
// the table engine then takes one at a time. A count item scans the table one
// entry at a time, fetching then comparing each, over its registered-read
// memory, stopping at a hit; an insert or a full table scans every entry. A read
// passes a read-wait state unless its index is beyond the table; a dropped item
// goes straight to the output state. Each result waits for out_ready. Valid bits
// clear at reset; no clearing pass is needed. min_payload_bytes_we loads the minimum.
`include "assert_macros.svh"

module flow_tuple_packet_byte_counter #(
	parameter int TABLE_ENTRIES = ftc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        min_payload_bytes_we,
	input  logic [7:0]  min_payload_bytes,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] outer_ethertype,
	input  logic [3:0]  ip_header_words,
	input  logic [15:0] ip_total_length,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [15:0] source_port,
	input  logic [15:0] destination_port,
	input  logic [3:0]  tcp_header_words,
	input  logic [7:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] flow_packets,
	output logic [31:0] flow_octets,
	output logic [31:0] key_source_address,
	output logic [31:0] key_destination_address,
	output logic [15:0] key_source_port,
	output logic [15:0] key_destination_port,
	output logic [7:0]  key_protocol
);

	logic          q_valid;
	logic          q_ready;
	ftc_pkg::cmd_t q_data;

	ftc_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.min_payload_bytes_we(min_payload_bytes_we),
		.min_payload_bytes   (min_payload_bytes),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.outer_ethertype     (outer_ethertype),
		.ip_header_words     (ip_header_words),
		.ip_total_length     (ip_total_length),
		.ip_protocol         (ip_protocol),
		.source_address      (source_address),
		.destination_address (destination_address),
		.source_port         (source_port),
		.destination_port    (destination_port),
		.tcp_header_words    (tcp_header_words),
		.entry_index         (entry_index),
		.q_valid             (q_valid),
		.q_ready             (q_ready),
		.q_data              (q_data)
	);

	ftc_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.q_valid                (q_valid),
		.q_ready                (q_ready),
		.q_data                 (q_data),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.status                 (status),
		.flow_packets           (flow_packets),
		.flow_octets            (flow_octets),
		.key_source_address     (key_source_address),
		.key_destination_address(key_destination_address),
		.key_source_port        (key_source_port),
		.key_destination_port   (key_destination_port),
		.key_protocol           (key_protocol)
	);

	`ASSERT_IMPLY(a_status_range, out_valid, status <= ftc_pkg::STATUS_READ_EMPTY)
	`ASSERT_IMPLY(a_drop_zero, out_valid && status == ftc_pkg::STATUS_DROPPED, flow_packets == 32'd0 && key_protocol == 8'd0)
	`ASSERT_IMPLY(a_insert_one, out_valid && status == ftc_pkg::STATUS_INSERTED, flow_packets == 32'd1)
	`ASSERT_IMPLY(a_full_zero, out_valid && status == ftc_pkg::STATUS_FULL, flow_packets == 32'd0 && flow_octets == 32'd0)

endmodule

/* rtl/core/ftc_front.sv */
module ftc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               min_payload_bytes_we,
	input  logic [7:0]         min_payload_bytes,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [15:0]        outer_ethertype,
	input  logic [3:0]         ip_header_words,
	input  logic [15:0]        ip_total_length,
	input  logic [7:0]         ip_protocol,
	input  logic [31:0]        source_address,
	input  logic [31:0]        destination_address,
	input  logic [15:0]        source_port,
	input  logic [15:0]        destination_port,
	input  logic [3:0]         tcp_header_words,
	input  logic [7:0]         entry_index,
	output logic               q_valid,
	input  logic               q_ready,
	output ftc_pkg::cmd_t      q_data
);

	logic [7:0]    min_q;
	ftc_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	logic          is_vlan, is_ipv4, is_tcp, is_udp, is_icmp, short_pay, drop;
	logic [5:0]    l4_bytes;
	logic [17:0]   payload;
	ftc_pkg::cmd_t cmd;
	logic          push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= ftc_pkg::MIN_PAYLOAD_RESET;
		end else if (min_payload_bytes_we) begin
			min_q <= min_payload_bytes;
		end
	end

	always_comb begin
		is_vlan   = outer_ethertype == ftc_pkg::ETYPE_VLAN;
		is_ipv4   = outer_ethertype == ftc_pkg::ETYPE_IPV4;
		is_tcp    = ip_protocol == ftc_pkg::PROTO_TCP;
		is_udp    = ip_protocol == ftc_pkg::PROTO_UDP;
		is_icmp   = ip_protocol == ftc_pkg::PROTO_ICMP;
		l4_bytes  = is_tcp ? {tcp_header_words, 2'b00} : (is_udp ? ftc_pkg::UDP_BYTES : 6'd0);
		payload   = {2'b00, ip_total_length} - {12'd0, ip_header_words, 2'b00}
			- {12'd0, l4_bytes};
		short_pay = $signed(payload) < $signed({10'd0, min_q});
		drop      = !(is_vlan || is_ipv4) || !(is_tcp || is_udp || is_icmp)
			|| (!is_icmp && short_pay);

		cmd.kind        = operation ? ftc_pkg::KIND_READ
			: (drop ? ftc_pkg::KIND_DROP : ftc_pkg::KIND_COUNT);
		cmd.entry_index = entry_index;
		cmd.sip         = source_address;
		cmd.dip         = destination_address;
		cmd.sport       = is_icmp ? 16'd0 : source_port;
		cmd.dport       = is_icmp ? 16'd0 : destination_port;
		cmd.proto       = ip_protocol;
		cmd.frame_bytes = ftc_pkg::ETHER_BYTES + (is_vlan ? ftc_pkg::TAG_BYTES : 17'd0)
			+ {1'b0, ip_total_length};
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_data   = fifo_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/core/ftc_back.sv */
module ftc_back #(
	parameter int TABLE_ENTRIES = ftc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  ftc_pkg::cmd_t q_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [31:0]   flow_packets,
	output logic [31:0]   flow_octets,
	output logic [31:0]   key_source_address,
	output logic [31:0]   key_destination_address,
	output logic [15:0]   key_source_port,
	output logic [15:0]   key_destination_port,
	output logic [7:0]    key_protocol
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_CMP    = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	ftc_pkg::row_t mem [TABLE_ENTRIES];
	ftc_pkg::row_t rd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [2:0]    state_q;
	ftc_pkg::cmd_t cmd_q;
	logic [IW-1:0] scan_q;
	logic [IW-1:0] free_q;
	logic          have_free_q;
	ftc_pkg::row_t res_q;
	logic [2:0]    res_status_q;
	ftc_pkg::row_t out_q;
	logic [2:0]    out_status_q;
	logic          out_valid_q;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] q_idx;
	logic          q_in_range;
	logic          key_hit;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	ftc_pkg::row_t wr_row;
	ftc_pkg::row_t key_row;

	assign q_ready    = state_q == ST_IDLE;
	assign q_idx      = IW'(q_data.entry_index);
	assign q_in_range = {24'd0, q_data.entry_index} < 32'(TABLE_ENTRIES);

	always_comb begin
		key_row.sip     = cmd_q.sip;
		key_row.dip     = cmd_q.dip;
		key_row.sport   = cmd_q.sport;
		key_row.dport   = cmd_q.dport;
		key_row.proto   = cmd_q.proto;
		key_row.packets = 32'd1;
		key_row.bytes   = {15'd0, cmd_q.frame_bytes};

		key_hit = valid_q[scan_q] && rd_q.sip == cmd_q.sip && rd_q.dip == cmd_q.dip
			&& rd_q.sport == cmd_q.sport && rd_q.dport == cmd_q.dport
			&& rd_q.proto == cmd_q.proto;

		rd_addr = (state_q == ST_IDLE) ? q_idx : scan_q;

		wr_en   = 1'b0;
		wr_addr = scan_q;
		wr_row  = key_row;
		if (state_q == ST_CMP) begin
			if (key_hit) begin
				wr_en          = 1'b1;
				wr_row.packets = rd_q.packets + 32'd1;
				wr_row.bytes   = rd_q.bytes + {15'd0, cmd_q.frame_bytes};
			end else if (scan_q == LAST) begin
				if (have_free_q) begin
					wr_en   = 1'b1;
					wr_addr = free_q;
				end else if (!valid_q[scan_q]) begin
					wr_en   = 1'b1;
					wr_addr = scan_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cmd_q <= q_data;
			res_q <= '0;
			if (q_data.kind == ftc_pkg::KIND_DROP) begin
				res_status_q <= ftc_pkg::STATUS_DROPPED;
			end else begin
				res_status_q <= ftc_pkg::STATUS_READ_EMPTY;
			end
		end else if (state_q == ST_RDWAIT) begin
			if (valid_q[scan_q]) begin
				res_q        <= rd_q;
				res_status_q <= ftc_pkg::STATUS_READ_VALID;
			end
		end else if (state_q == ST_CMP && wr_en) begin
			res_q        <= wr_row;
			res_status_q <= key_hit ? ftc_pkg::STATUS_COUNTED : ftc_pkg::STATUS_INSERTED;
		end else if (state_q == ST_CMP && scan_q == LAST) begin
			res_q        <= {cmd_q.sip, cmd_q.dip, cmd_q.sport, cmd_q.dport, cmd_q.proto,
				64'd0};
			res_status_q <= ftc_pkg::STATUS_FULL;
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_q        <= res_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			free_q      <= '0;
			have_free_q <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						scan_q      <= (q_data.kind == ftc_pkg::KIND_READ) ? q_idx : '0;
						have_free_q <= 1'b0;
						if (q_data.kind == ftc_pkg::KIND_COUNT) begin
							state_q <= ST_FETCH;
						end else if (q_data.kind == ftc_pkg::KIND_READ && q_in_range) begin
							state_q <= ST_RDWAIT;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (key_hit || scan_q == LAST) begin
						state_q <= ST_OUT;
					end else begin
						if (!valid_q[scan_q] && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q      <= scan_q;
						end
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid               = out_valid_q;
	assign status                  = out_status_q;
	assign flow_packets            = out_q.packets;
	assign flow_octets             = out_q.bytes;
	assign key_source_address      = out_q.sip;
	assign key_destination_address = out_q.dip;
	assign key_source_port         = out_q.sport;
	assign key_destination_port    = out_q.dport;
	assign key_protocol            = out_q.proto;

endmodule

/* tb/flow_tuple_packet_byte_counter_tb.sv */
`timescale 1ns / 1ps

module flow_tuple_packet_byte_counter_tb;

	localparam int ENTRIES = ftc_pkg::TABLE_ENTRIES_DEF;
	localparam int IDLE_PCT = 22;
	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		bit        op;
		bit [15:0] etype;
		bit [3:0]  ihl;
		bit [15:0] tlen;
		bit [7:0]  proto;
		bit [31:0] sip;
		bit [31:0] dip;
		bit [15:0] sport;
		bit [15:0] dport;
		bit [3:0]  thl;
		bit [7:0]  idx;
	} pkt_t;

	typedef struct {
		bit [2:0]  st;
		bit [31:0] packets;
		bit [31:0] bytes;
		bit [31:0] sip;
		bit [31:0] dip;
		bit [15:0] sport;
		bit [15:0] dport;
		bit [7:0]  proto;
	} flow_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [15:0] outer_ethertype;
	logic [3:0] ip_header_words;
	logic [15:0] ip_total_length;
	logic [7:0] ip_protocol;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [15:0] source_port;
	logic [15:0] destination_port;
	logic [3:0] tcp_header_words;
	logic [7:0] entry_index;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [31:0] flow_packets;
	logic [31:0] flow_octets;
	logic [31:0] key_source_address;
	logic [31:0] key_destination_address;
	logic [15:0] key_source_port;
	logic [15:0] key_destination_port;
	logic [7:0] key_protocol;

	flow_tuple_packet_byte_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.min_payload_bytes_we(cfg_we),
		.min_payload_bytes(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.outer_ethertype(outer_ethertype),
		.ip_header_words(ip_header_words),
		.ip_total_length(ip_total_length),
		.ip_protocol(ip_protocol),
		.source_address(source_address),
		.destination_address(destination_address),
		.source_port(source_port),
		.destination_port(destination_port),
		.tcp_header_words(tcp_header_words),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.flow_packets(flow_packets),
		.flow_octets(flow_octets),
		.key_source_address(key_source_address),
		.key_destination_address(key_destination_address),
		.key_source_port(key_source_port),
		.key_destination_port(key_destination_port),
		.key_protocol(key_protocol)
	);

	bit        tbl_valid [ENTRIES];
	bit [31:0] tbl_sip [ENTRIES];
	bit [31:0] tbl_dip [ENTRIES];
	bit [15:0] tbl_sport [ENTRIES];
	bit [15:0] tbl_dport [ENTRIES];
	bit [7:0]  tbl_proto [ENTRIES];
	bit [31:0] tbl_packets [ENTRIES];
	bit [31:0] tbl_bytes [ENTRIES];
	int        min_payload;
	int        used_entries;

	flow_result_t expected_q[$];
	int errors;
	bit quiet;
	bit hold_req;
	logic hold_off;
	int stall_count;

	pkt_t flows[24];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic predict_result(input pkt_t p, output flow_result_t r);
		int payload;
		int frame_bytes;
		int free_slot;
		bit [15:0] sp;
		bit [15:0] dp;
		r = '{default: 0};
		if (p.op) begin
			if (tbl_valid[p.idx]) begin
				r.st = ftc_pkg::STATUS_READ_VALID;
				r.packets = tbl_packets[p.idx];
				r.bytes = tbl_bytes[p.idx];
				r.sip = tbl_sip[p.idx];
				r.dip = tbl_dip[p.idx];
				r.sport = tbl_sport[p.idx];
				r.dport = tbl_dport[p.idx];
				r.proto = tbl_proto[p.idx];
			end else
				r.st = ftc_pkg::STATUS_READ_EMPTY;
			return;
		end
		r.st = ftc_pkg::STATUS_DROPPED;
		if (p.etype == ftc_pkg::ETYPE_VLAN)
			frame_bytes = 18 + p.tlen;
		else if (p.etype == ftc_pkg::ETYPE_IPV4)
			frame_bytes = 14 + p.tlen;
		else
			return;
		payload = int'(p.tlen) - 4 * int'(p.ihl);
		sp = p.sport;
		dp = p.dport;
		if (p.proto == ftc_pkg::PROTO_TCP)
			payload -= 4 * int'(p.thl);
		else if (p.proto == ftc_pkg::PROTO_UDP)
			payload -= 8;
		else if (p.proto == ftc_pkg::PROTO_ICMP) begin
			sp = 0;
			dp = 0;
		end else
			return;
		if (p.proto != ftc_pkg::PROTO_ICMP && payload < min_payload)
			return;
		r.sip = p.sip;
		r.dip = p.dip;
		r.sport = sp;
		r.dport = dp;
		r.proto = p.proto;
		free_slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (tbl_sip[i] == p.sip && tbl_dip[i] == p.dip && tbl_sport[i] == sp
						&& tbl_dport[i] == dp && tbl_proto[i] == p.proto) begin
					tbl_packets[i] += 1;
					tbl_bytes[i] += frame_bytes;
					r.st = ftc_pkg::STATUS_COUNTED;
					r.packets = tbl_packets[i];
					r.bytes = tbl_bytes[i];
					return;
				end
			end else if (free_slot < 0)
				free_slot = i;
		end
		if (free_slot < 0) begin
			r.st = ftc_pkg::STATUS_FULL;
			return;
		end
		tbl_valid[free_slot] = 1;
		tbl_sip[free_slot] = p.sip;
		tbl_dip[free_slot] = p.dip;
		tbl_sport[free_slot] = sp;
		tbl_dport[free_slot] = dp;
		tbl_proto[free_slot] = p.proto;
		tbl_packets[free_slot] = 1;
		tbl_bytes[free_slot] = frame_bytes;
		used_entries++;
		r.st = ftc_pkg::STATUS_INSERTED;
		r.packets = 1;
		r.bytes = frame_bytes;
	endtask

	always @(posedge clk) begin
		pkt_t p;
		flow_result_t r;
		if (arst_n && in_valid && in_ready) begin
			p.op = operation;
			p.etype = outer_ethertype;
			p.ihl = ip_header_words;
			p.tlen = ip_total_length;
			p.proto = ip_protocol;
			p.sip = source_address;
			p.dip = destination_address;
			p.sport = source_port;
			p.dport = destination_port;
			p.thl = tcp_header_words;
			p.idx = entry_index;
			predict_result(p, r);
			expected_q.push_back(r);
		end
	end

	always @(posedge clk) begin
		flow_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", {29'd0, status}, 32'd0);
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st) report("status", status, e.st);
				if (flow_packets !== e.packets) report("flow_packets", flow_packets, e.packets);
				if (flow_octets !== e.bytes) report("flow_octets", flow_octets, e.bytes);
				if (key_source_address !== e.sip)
					report("key_source_address", key_source_address, e.sip);
				if (key_destination_address !== e.dip)
					report("key_destination_address", key_destination_address, e.dip);
				if (key_source_port !== e.sport)
					report("key_source_port", key_source_port, e.sport);
				if (key_destination_port !== e.dport)
					report("key_destination_port", key_destination_port, e.dport);
				if (key_protocol !== e.proto) report("key_protocol", key_protocol, e.proto);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && (quiet || $urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else if (stall_count >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			stall_count <= stall_count + 1;
	end

	task automatic send_item(input pkt_t p);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= p.op;
		outer_ethertype <= p.etype;
		ip_header_words <= p.ihl;
		ip_total_length <= p.tlen;
		ip_protocol <= p.proto;
		source_address <= p.sip;
		destination_address <= p.dip;
		source_port <= p.sport;
		destination_port <= p.dport;
		tcp_header_words <= p.thl;
		entry_index <= p.idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_min_payload(input bit [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_payload = v;
	endtask

	function automatic pkt_t frame(input bit [7:0] proto, input bit [31:0] sip,
			input bit [31:0] dip, input bit [15:0] sport, input bit [15:0] dport,
			input bit [15:0] tlen);
		pkt_t p;
		p.op = 0;
		p.etype = ftc_pkg::ETYPE_IPV4;
		p.ihl = 5;
		p.tlen = tlen;
		p.proto = proto;
		p.sip = sip;
		p.dip = dip;
		p.sport = sport;
		p.dport = dport;
		p.thl = 5;
		p.idx = $urandom;
		return p;
	endfunction

	function automatic pkt_t read_item(input bit [7:0] idx);
		pkt_t p;
		p = frame(ftc_pkg::PROTO_TCP, $urandom, $urandom, $urandom, $urandom, $urandom);
		p.op = 1;
		p.etype = $urandom;
		p.ihl = $urandom;
		p.thl = $urandom;
		p.idx = idx;
		return p;
	endfunction

	task automatic test_directed();
		pkt_t p;
		send_item(frame(ftc_pkg::PROTO_TCP, 32'h0A000001, 32'h0A000002, 1000, 80, 100));
		p = frame(ftc_pkg::PROTO_UDP, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, 16'hFFFF);
		p.etype = ftc_pkg::ETYPE_VLAN;
		send_item(p);
		send_item(p);
		p = frame(ftc_pkg::PROTO_ICMP, 32'h01020304, 32'h05060708, 16'h1234, 16'h5678, 0);
		send_item(p);
		p.sport = 16'hABCD;
		send_item(p);
		p = frame(ftc_pkg::PROTO_TCP, 1, 2, 3, 4, 200);
		p.etype = 16'h86DD;
		send_item(p);
		p = frame(8'd47, 1, 2, 3, 4, 200);
		send_item(p);
		p = frame(ftc_pkg::PROTO_TCP, 7, 8, 9, 10, 46);
		send_item(p);
		p.tlen = 47;
		send_item(p);
		p = frame(ftc_pkg::PROTO_TCP, 7, 8, 9, 10, 20);
		p.ihl = 15;
		p.thl = 15;
		send_item(p);
		send_item(frame(ftc_pkg::PROTO_UDP, 11, 12, 4789, 4789, 35));
		send_item(frame(ftc_pkg::PROTO_UDP, 11, 12, 4789, 4789, 34));
		p = frame(ftc_pkg::PROTO_TCP, 32'h0A000001, 32'h0A000002, 1000, 80, 16'hFFFF);
		p.etype = ftc_pkg::ETYPE_VLAN;
		send_item(p);
		send_item(read_item(0));
		send_item(read_item(1));
		send_item(read_item(3));
		send_item(read_item(200));
		send_item(read_item(255));
	endtask

	task automatic test_config();
		pkt_t p;
		p = frame(ftc_pkg::PROTO_TCP, 21, 22, 23, 24, 40);
		write_min_payload(8'd0);
		send_item(p);
		p.tlen = 39;
		send_item(p);
		write_min_payload(8'd255);
		p.tlen = 294;
		send_item(p);
		p.tlen = 295;
		send_item(p);
		send_item(frame(ftc_pkg::PROTO_UDP, 25, 26, 27, 28, 290));
		write_min_payload(8'd7);
		send_item(frame(ftc_pkg::PROTO_UDP, 25, 26, 27, 28, 35));
	endtask

	function automatic pkt_t random_frame();
		pkt_t p;
		int k;
		k = $urandom_range(99);
		if (k < 12)
			return read_item($urandom_range(99) < 80 ? $urandom_range(40) : $urandom);
		p = flows[$urandom_range(23)];
		p.idx = $urandom;
		p.etype = $urandom_range(1) ? ftc_pkg::ETYPE_VLAN : ftc_pkg::ETYPE_IPV4;
		p.ihl = $urandom_range(99) < 70 ? 5 : $urandom;
		p.thl = $urandom_range(99) < 70 ? 5 : $urandom;
		p.tlen = $urandom_range(99) < 80 ? $urandom_range(100, 65535) : $urandom_range(120);
		if (k < 20)
			p.etype = $urandom;
		else if (k < 26)
			p.proto = $urandom;
		return p;
	endfunction

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 3 && i < count / 3 + 250);
			send_item(random_frame());
		end
		quiet = 0;
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1;
		for (int i = 0; i < 12; i++)
			send_item(random_frame());
	endtask

	task automatic test_table_full();
		pkt_t p;
		int extra;
		extra = 0;
		while (extra < 10) begin
			if (used_entries >= ENTRIES)
				extra++;
			p = frame(ftc_pkg::PROTO_UDP, 32'hC0A80000 + used_entries + extra * 1000,
				$urandom, $urandom, $urandom, $urandom_range(64, 1500));
			send_item(p);
			drain();
		end
		for (int i = 0; i < 40; i++)
			send_item(read_item($urandom));
		for (int i = 0; i < 6; i++) begin
			p = flows[$urandom_range(23)];
			p.etype = ftc_pkg::ETYPE_IPV4;
			p.ihl = 5;
			p.thl = 5;
			p.tlen = 1500;
			send_item(p);
		end
		send_item(read_item(255));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		operation = 1'b0;
		outer_ethertype = '0;
		ip_header_words = '0;
		ip_total_length = '0;
		ip_protocol = '0;
		source_address = '0;
		destination_address = '0;
		source_port = '0;
		destination_port = '0;
		tcp_header_words = '0;
		entry_index = '0;
		errors = 0;
		quiet = 0;
		hold_req = 0;
		min_payload = ftc_pkg::MIN_PAYLOAD_RESET;
		used_entries = 0;
		for (int i = 0; i < ENTRIES; i++)
			tbl_valid[i] = 0;
		for (int i = 0; i < 24; i++) begin
			case (i % 3)
				0: flows[i] = frame(ftc_pkg::PROTO_TCP, $urandom, $urandom, $urandom,
					$urandom, 0);
				1: flows[i] = frame(ftc_pkg::PROTO_UDP, $urandom, $urandom, $urandom,
					$urandom, 0);
				default: flows[i] = frame(ftc_pkg::PROTO_ICMP, $urandom, $urandom,
					$urandom, $urandom, 0);
			endcase
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config();
		test_random(1500);
		test_backpressure();
		test_random(100);
		test_table_full();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ftc_pkg.sv
rtl/core/ftc_front.sv
rtl/core/ftc_back.sv
rtl/core/flow_tuple_packet_byte_counter.sv
tb/flow_tuple_packet_byte_counter_tb.sv
